### hw/rtl/dps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dps_pkg;

	// Q16.16 constants
	localparam logic        [19:0] GRAVITY  = 20'd642908;   // 9.81
	localparam logic signed [15:0] BOUNCE   = 16'sd19661;   // 0.3
	localparam logic signed [17:0] FRICTION = 18'sd52429;   // 0.8
	localparam logic signed [31:0] SNAP     = 32'sd6554;    // 0.1

	localparam logic [9:0]  STILL_MAX = 10'd1023;

	// register map, index = paddr[2]
	localparam logic REG_SLEEP_LIMIT = 1'b0;
	localparam logic REG_FRAMES      = 1'b1;

	localparam logic [23:0] SLEEP_LIMIT_RST = 24'd655;
	localparam logic [9:0]  FRAMES_RST      = 10'd60;
	localparam logic [47:0] TH2_RST = {24'd0, SLEEP_LIMIT_RST} * {24'd0, SLEEP_LIMIT_RST};

	typedef struct packed {
		logic        [16:0] time_step;
		logic signed [31:0] in_pos_x;
		logic signed [31:0] in_pos_y;
		logic signed [31:0] in_pos_z;
		logic signed [31:0] in_vel_x;
		logic signed [31:0] in_vel_y;
		logic signed [31:0] in_vel_z;
		logic signed [31:0] in_life;
		logic               in_asleep;
		logic        [9:0]  in_still_count;
	} dps_in_t;

	typedef struct packed {
		logic signed [31:0] out_pos_x;
		logic signed [31:0] out_pos_y;
		logic signed [31:0] out_pos_z;
		logic signed [31:0] out_vel_x;
		logic signed [31:0] out_vel_y;
		logic signed [31:0] out_vel_z;
		logic signed [31:0] out_life;
		logic               out_asleep;
		logic        [9:0]  out_still_count;
		logic               expired;
	} dps_out_t;

	// clamp a 34-bit signed value to signed 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -34'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/debris_particle_step_unit.sv
// Debris particle step: sleep rule, gravity, Euler integration, ground bounce.
// Four register stages lie between input transaction and result; the last one
// is the output register.
// Throughput: one transaction per cycle while result_stall is low; each stage advances when empty or drained.
// Reset: arst_n clears all stage valid bits and loads sleep_speed_limit = 655
// and frames_to_sleep = 60. Data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module debris_particle_step_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// item channel
	input  wire dps_pkg::dps_in_t  item,
	input  wire logic              item_valid,
	output logic                   item_stall,
	// result channel
	output dps_pkg::dps_out_t      result,
	output logic                   result_valid,
	input  wire logic              result_stall,
	// APB config port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	import dps_pkg::*;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [23:0] limit_q;
	logic [9:0]  frames_q;
	logic [47:0] th2_q;     // limit squared, kept ready for the speed compares
	logic        cfg_wr;
	logic        cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= SLEEP_LIMIT_RST;
			frames_q <= FRAMES_RST;
			th2_q    <= TH2_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_SLEEP_LIMIT: begin
					limit_q <= pwdata[23:0];
					th2_q   <= {24'd0, pwdata[23:0]} * {24'd0, pwdata[23:0]};
				end
				REG_FRAMES: begin
					frames_q <= pwdata[9:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_SLEEP_LIMIT: prdata = {8'd0, limit_q};
			REG_FRAMES:      prdata = {22'd0, frames_q};
			default:         prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------------
	// Pipeline flow control: a stage takes new data when it is empty or
	// when the stage after it takes its contents. Bubbles collapse.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	assign en4 = !v_s4 || !result_stall;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign item_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= item_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: squares for the speed test, dt products, friction products,
	// lifetime update and the saturating still count increment.
	// ------------------------------------------------------------------
	logic signed [63:0] sq_x, sq_y, sq_z;
	logic        [36:0] gdt_prod;
	logic signed [17:0] dt_in;
	logic signed [49:0] vxdt_prod, vzdt_prod;
	logic signed [49:0] vxf_prod, vzf_prod;
	logic signed [33:0] life_diff;
	logic signed [31:0] life_new;
	logic        [9:0]  cnt_inc;

	assign sq_x     = item.in_vel_x * item.in_vel_x;
	assign sq_y     = item.in_vel_y * item.in_vel_y;
	assign sq_z     = item.in_vel_z * item.in_vel_z;
	assign gdt_prod = {17'd0, GRAVITY} * {20'd0, item.time_step};
	assign dt_in    = {1'b0, item.time_step};
	assign vxdt_prod = item.in_vel_x * dt_in;
	assign vzdt_prod = item.in_vel_z * dt_in;
	assign vxf_prod  = item.in_vel_x * FRICTION;
	assign vzf_prod  = item.in_vel_z * FRICTION;
	assign life_diff = {{2{item.in_life[31]}}, item.in_life} - {17'd0, item.time_step};
	assign life_new  = sat32(life_diff);
	assign cnt_inc   = (item.in_still_count == STILL_MAX) ? STILL_MAX
	                                                    : item.in_still_count + 10'd1;

	dps_in_t            item_s1;
	logic        [62:0] sqx_s1, sqy_s1, sqz_s1;
	logic        [20:0] gdt_s1;
	logic signed [33:0] vxdt_s1, vzdt_s1;   // floor(v*dt), before clamping
	logic signed [31:0] vxf_s1, vzf_s1;     // v*0.8 always fits 32 bits
	logic signed [31:0] life_s1;
	logic               expired_s1;
	logic        [9:0]  cnt_inc_s1;

	always_ff @(posedge clk) begin
		if (en1 && item_valid) begin
			item_s1    <= item;
			sqx_s1     <= sq_x[62:0];
			sqy_s1     <= sq_y[62:0];
			sqz_s1     <= sq_z[62:0];
			gdt_s1     <= gdt_prod[36:16];
			vxdt_s1    <= vxdt_prod[49:16];
			vzdt_s1    <= vzdt_prod[49:16];
			vxf_s1     <= vxf_prod[47:16];
			vzf_s1     <= vzf_prod[47:16];
			life_s1    <= life_new;
			expired_s1 <= (life_new <= 32'sd0);
			cnt_inc_s1 <= cnt_inc;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: squared speed sum, vy after gravity, x and z positions.
	// ------------------------------------------------------------------
	logic        [63:0] spd2;
	logic signed [31:0] vy_grav;
	logic signed [31:0] dx, dz, px_new, pz_new;

	assign spd2    = {1'b0, sqx_s1} + {1'b0, sqy_s1} + {1'b0, sqz_s1};
	assign vy_grav = sat32({{2{item_s1.in_vel_y[31]}}, item_s1.in_vel_y} - {13'd0, gdt_s1});
	assign dx      = sat32(vxdt_s1);
	assign dz      = sat32(vzdt_s1);
	assign px_new  = sat32({{2{item_s1.in_pos_x[31]}}, item_s1.in_pos_x}
	                     + {{2{dx[31]}}, dx});
	assign pz_new  = sat32({{2{item_s1.in_pos_z[31]}}, item_s1.in_pos_z}
	                     + {{2{dz[31]}}, dz});

	dps_in_t            item_s2;
	logic        [63:0] spd2_s2;
	logic signed [31:0] vy1_s2, px1_s2, pz1_s2;
	logic signed [31:0] vxf_s2, vzf_s2;
	logic signed [31:0] life_s2;
	logic               expired_s2;
	logic        [9:0]  cnt_inc_s2;

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			item_s2    <= item_s1;
			spd2_s2    <= spd2;
			vy1_s2     <= vy_grav;
			px1_s2     <= px_new;
			pz1_s2     <= pz_new;
			vxf_s2     <= vxf_s1;
			vzf_s2     <= vzf_s1;
			life_s2    <= life_s1;
			expired_s2 <= expired_s1;
			cnt_inc_s2 <= cnt_inc_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: sleep rule, vy*dt and the bounce product of vy.
	// ------------------------------------------------------------------
	logic               slow, fast;
	logic               asleep_nx, fell_nx;
	logic        [9:0]  cnt_nx;
	logic signed [17:0] dt_s2;
	logic signed [49:0] vydt_prod;
	logic signed [32:0] vy_neg;
	logic signed [48:0] vyb_prod;

	assign slow = spd2_s2 < {16'd0, th2_q};
	assign fast = spd2_s2 > {14'd0, th2_q, 2'b00};   // speed above twice the limit

	always_comb begin
		asleep_nx = item_s2.in_asleep;
		cnt_nx    = item_s2.in_still_count;
		fell_nx   = 1'b0;
		if (item_s2.in_asleep) begin
			if (fast) begin
				asleep_nx = 1'b0;
				cnt_nx    = 10'd0;
			end
		end else begin
			if (slow) begin
				cnt_nx = cnt_inc_s2;
				if (cnt_inc_s2 >= frames_q) begin
					asleep_nx = 1'b1;
					fell_nx   = 1'b1;
				end
			end else begin
				cnt_nx = 10'd0;
			end
		end
	end

	assign dt_s2     = {1'b0, item_s2.time_step};
	assign vydt_prod = vy1_s2 * dt_s2;
	assign vy_neg    = 33'sd0 - {vy1_s2[31], vy1_s2};
	assign vyb_prod  = vy_neg * BOUNCE;

	dps_in_t            item_s3;
	logic signed [33:0] vydt_s3;
	logic signed [31:0] vyb_s3;             // -vy*0.3 always fits 32 bits
	logic signed [31:0] vy1_s3, px1_s3, pz1_s3;
	logic signed [31:0] vxf_s3, vzf_s3;
	logic signed [31:0] life_s3;
	logic               expired_s3;
	logic               asleep_s3, fell_s3;
	logic        [9:0]  cnt_s3;

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			item_s3    <= item_s2;
			vydt_s3    <= vydt_prod[49:16];
			vyb_s3     <= vyb_prod[47:16];
			vy1_s3     <= vy1_s2;
			px1_s3     <= px1_s2;
			pz1_s3     <= pz1_s2;
			vxf_s3     <= vxf_s2;
			vzf_s3     <= vzf_s2;
			life_s3    <= life_s2;
			expired_s3 <= expired_s2;
			asleep_s3  <= asleep_nx;
			fell_s3    <= fell_nx;
			cnt_s3     <= cnt_nx;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: y position, ground clamp and bounce, final select into the
	// output register.
	// ------------------------------------------------------------------
	logic signed [31:0] dy, py_new, vyb_snap;
	logic               below;
	dps_out_t           res_nx;

	assign dy       = sat32(vydt_s3);
	assign py_new   = sat32({{2{item_s3.in_pos_y[31]}}, item_s3.in_pos_y}
	                      + {{2{dy[31]}}, dy});
	assign below    = py_new[31];
	assign vyb_snap = (vyb_s3 < SNAP && vyb_s3 > -SNAP) ? 32'sd0 : vyb_s3;

	always_comb begin
		res_nx.out_life        = life_s3;
		res_nx.expired         = expired_s3;
		res_nx.out_asleep      = asleep_s3;
		res_nx.out_still_count = cnt_s3;
		if (asleep_s3) begin
			// no integration; an item that just fell asleep loses its velocity
			res_nx.out_pos_x = item_s3.in_pos_x;
			res_nx.out_pos_y = item_s3.in_pos_y;
			res_nx.out_pos_z = item_s3.in_pos_z;
			res_nx.out_vel_x = fell_s3 ? 32'sd0 : item_s3.in_vel_x;
			res_nx.out_vel_y = fell_s3 ? 32'sd0 : item_s3.in_vel_y;
			res_nx.out_vel_z = fell_s3 ? 32'sd0 : item_s3.in_vel_z;
		end else if (below) begin
			res_nx.out_pos_x = px1_s3;
			res_nx.out_pos_y = 32'sd0;
			res_nx.out_pos_z = pz1_s3;
			res_nx.out_vel_x = vxf_s3;
			res_nx.out_vel_y = vyb_snap;
			res_nx.out_vel_z = vzf_s3;
		end else begin
			res_nx.out_pos_x = px1_s3;
			res_nx.out_pos_y = py_new;
			res_nx.out_pos_z = pz1_s3;
			res_nx.out_vel_x = item_s3.in_vel_x;
			res_nx.out_vel_y = vy1_s3;
			res_nx.out_vel_z = item_s3.in_vel_z;
		end
	end

	dps_out_t res_s4;

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			res_s4 <= res_nx;
		end
	end

	assign result       = res_s4;
	assign result_valid = v_s4;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// an awake record has been integrated and clamped, so it never sits below ground
	ast_awake_above_ground: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.out_asleep |-> !result.out_pos_y[31])
		else $error("awake result below ground");

	// expired flag agrees with the lifetime carried down the pipe
	ast_expired_life: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.expired == (result.out_life <= 32'sd0)))
		else $error("expired flag does not match lifetime");

	// an empty first stage always takes a transaction
	ast_s1_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !item_stall)
		else $error("input stalled with empty first stage");

	// a stage that drained with no upstream data becomes empty
	ast_s4_drain: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !v_s3 |=> !result_valid)
		else $error("output stage did not drain");

endmodule

`default_nettype wire
